// ===== rtl/core/lwf_pkg.sv =====
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types and constants for the left wall follow controller.
// ----------------------------------------------------------------------------
package lwf_pkg;

    localparam int unsigned SECTOR_WIDTH   = 10;
    localparam int unsigned BEAMS_PER_SCAN = 360;

    localparam int unsigned DIST_W  = 14;
    localparam int unsigned BEAM_W  = 9;
    localparam int unsigned LIN_W   = 5;
    localparam int unsigned ANG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BEAM_W-1:0] FWD_START  = BEAM_W'(0);
    localparam logic [BEAM_W-1:0] FL_START   = BEAM_W'(40);
    localparam logic [BEAM_W-1:0] LEFT_START = BEAM_W'(85);

    localparam logic [DIST_W-1:0] FAR_RANGE_CM = DIST_W'(10000);

    localparam logic [DIST_W-1:0] MAX_DIST_RST = DIST_W'(50);
    localparam logic [DIST_W-1:0] MIN_DIST_RST = DIST_W'(30);
    localparam logic [DIST_W-1:0] FAR_DIST_RST = DIST_W'(100);

    // speed commands, hundredths
    localparam logic [LIN_W-1:0]        LIN_SLOW   = LIN_W'(20);
    localparam logic [LIN_W-1:0]        LIN_CRUISE = LIN_W'(30);
    localparam logic [LIN_W-1:0]        LIN_CREEP  = LIN_W'(3);
    localparam logic [LIN_W-1:0]        LIN_EDGE   = LIN_W'(10);
    localparam logic [LIN_W-1:0]        LIN_STOP   = LIN_W'(0);
    localparam logic signed [ANG_W-1:0] ANG_AWAY   = -8'sd30;
    localparam logic signed [ANG_W-1:0] ANG_TOWARD = 8'sd30;
    localparam logic signed [ANG_W-1:0] ANG_ROUND  = 8'sd60;
    localparam logic signed [ANG_W-1:0] ANG_RIGHT  = -8'sd80;
    localparam logic signed [ANG_W-1:0] ANG_NONE   = 8'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DIST = 2'd0,
        REG_MIN_DIST = 2'd1,
        REG_FAR_DIST = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_FOLLOW  = 2'd0,
        MODE_WALLEND = 2'd1,
        MODE_RIGHT   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [DIST_W-1:0] max_dist;
        logic [DIST_W-1:0] min_dist;
        logic [DIST_W-1:0] far_dist;
    } thresholds_t;

    typedef struct packed {
        logic [DIST_W-1:0] forward;
        logic [DIST_W-1:0] front_left;
        logic [DIST_W-1:0] left;
    } sector_mins_t;

    function automatic logic sector_hit(input logic [BEAM_W-1:0] beam,
                                        input logic [BEAM_W-1:0] start);
        logic [BEAM_W:0] stop;
        stop = {1'b0, start} + (BEAM_W+1)'(SECTOR_WIDTH);
        return (beam >= start) && ({1'b0, beam} < stop)
            && ({1'b0, beam} < (BEAM_W+1)'(BEAMS_PER_SCAN));
    endfunction

endpackage

// ===== rtl/core/lwf_sectors.sv =====
// ----------------------------------------------------------------------------
// lwf_sectors
// Running minimum range for the forward, front-left and left sectors.
// ----------------------------------------------------------------------------
module lwf_sectors (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_en,
    input  logic [lwf_pkg::BEAM_W-1:0]    beam_index,
    input  logic [lwf_pkg::DIST_W-1:0]    range_cm,
    input  logic                          no_return,
    output lwf_pkg::sector_mins_t         mins
);

    lwf_pkg::sector_mins_t        mins_reg;
    lwf_pkg::sector_mins_t        mins_next;
    logic [lwf_pkg::DIST_W-1:0]   sample_cm;

    // no return, zero or out-of-scale range all read as far
    always_comb
    begin
        if (no_return || range_cm == '0 || range_cm > lwf_pkg::FAR_RANGE_CM)
            sample_cm = lwf_pkg::FAR_RANGE_CM;
        else
            sample_cm = range_cm;
    end

    always_comb
    begin
        mins_next = mins_reg;
        if (sample_en)
        begin
            if (lwf_pkg::sector_hit(beam_index, lwf_pkg::FWD_START) &&
                (beam_index == lwf_pkg::FWD_START || sample_cm < mins_reg.forward))
                mins_next.forward = sample_cm;
            if (lwf_pkg::sector_hit(beam_index, lwf_pkg::FL_START) &&
                (beam_index == lwf_pkg::FL_START || sample_cm < mins_reg.front_left))
                mins_next.front_left = sample_cm;
            if (lwf_pkg::sector_hit(beam_index, lwf_pkg::LEFT_START) &&
                (beam_index == lwf_pkg::LEFT_START || sample_cm < mins_reg.left))
                mins_next.left = sample_cm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mins_reg.forward    <= lwf_pkg::FAR_RANGE_CM;
            mins_reg.front_left <= lwf_pkg::FAR_RANGE_CM;
            mins_reg.left       <= lwf_pkg::FAR_RANGE_CM;
        end
        else
        begin
            mins_reg <= mins_next;
        end
    end

    assign mins = mins_reg;

endmodule

// ===== rtl/core/lwf_mode_fsm.sv =====
// ----------------------------------------------------------------------------
// lwf_mode_fsm
// Follow wall / wall end / right turn machine, one decision per tick.
// ----------------------------------------------------------------------------
module lwf_mode_fsm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_en,
    input  lwf_pkg::thresholds_t                thr,
    input  lwf_pkg::sector_mins_t               mins,
    output logic                                cmd_valid,
    output logic [lwf_pkg::LIN_W-1:0]           cmd_linear,
    output logic signed [lwf_pkg::ANG_W-1:0]    cmd_angular
);

    lwf_pkg::mode_t mode_reg;
    lwf_pkg::mode_t mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= lwf_pkg::MODE_FOLLOW;
        else
            mode_reg <= mode_next;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        cmd_valid   = 1'b0;
        cmd_linear  = lwf_pkg::LIN_STOP;
        cmd_angular = lwf_pkg::ANG_NONE;
        if (tick_en)
        begin
            unique case (mode_reg)
                lwf_pkg::MODE_FOLLOW:
                begin
                    if (mins.forward > thr.max_dist)
                    begin
                        if (mins.front_left < thr.far_dist)
                        begin
                            cmd_valid = 1'b1;
                            if (mins.front_left < thr.min_dist)
                            begin
                                cmd_linear  = lwf_pkg::LIN_SLOW;
                                cmd_angular = lwf_pkg::ANG_AWAY;
                            end
                            else if (mins.front_left > thr.max_dist)
                            begin
                                cmd_linear  = lwf_pkg::LIN_SLOW;
                                cmd_angular = lwf_pkg::ANG_TOWARD;
                            end
                            else
                            begin
                                cmd_linear  = lwf_pkg::LIN_CRUISE;
                                cmd_angular = lwf_pkg::ANG_NONE;
                            end
                        end
                        else
                        begin
                            mode_next = lwf_pkg::MODE_WALLEND;
                        end
                    end
                    else
                    begin
                        mode_next = lwf_pkg::MODE_RIGHT;
                    end
                end
                lwf_pkg::MODE_WALLEND:
                begin
                    if (mins.front_left > thr.max_dist)
                    begin
                        cmd_valid   = 1'b1;
                        cmd_linear  = lwf_pkg::LIN_CREEP;
                        cmd_angular = lwf_pkg::ANG_ROUND;
                    end
                    else if (mins.left > thr.max_dist && mins.front_left > thr.min_dist)
                    begin
                        cmd_valid   = 1'b1;
                        cmd_linear  = lwf_pkg::LIN_EDGE;
                        cmd_angular = lwf_pkg::ANG_NONE;
                    end
                    else
                    begin
                        mode_next = lwf_pkg::MODE_FOLLOW;
                    end
                end
                lwf_pkg::MODE_RIGHT:
                begin
                    if (mins.forward > thr.max_dist)
                    begin
                        mode_next = lwf_pkg::MODE_FOLLOW;
                    end
                    else
                    begin
                        cmd_valid   = 1'b1;
                        cmd_linear  = lwf_pkg::LIN_STOP;
                        cmd_angular = lwf_pkg::ANG_RIGHT;
                    end
                end
                default:
                begin
                    // unused mode code: stop and stay
                    cmd_valid   = 1'b1;
                    cmd_linear  = lwf_pkg::LIN_STOP;
                    cmd_angular = lwf_pkg::ANG_NONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/left_wall_follow_controller.sv =====
// ----------------------------------------------------------------------------
// left_wall_follow_controller
// Left-hand wall follower: sector minima from laser beats, speed command
// on control ticks.
// ----------------------------------------------------------------------------
// Each input beat is either one laser beam sample or one control tick. A beat
// is taken into an input register, processed there (sector minimum update or
// one step of the mode machine) and, when a tick produces a speed command,
// placed in the output register. The block takes one beat every cycle unless
// stalled. The only thing that holds the input back is a command waiting in
// the output register while out_ready is low. Threshold registers are written
// through cfg_we, cfg_index and cfg_data and should be changed only while the
// block is idle.
module left_wall_follow_controller (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [lwf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lwf_pkg::DIST_W-1:0]          cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [lwf_pkg::BEAM_W-1:0]          beam_index,
    input  logic [lwf_pkg::DIST_W-1:0]          range_cm,
    input  logic                                no_return,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lwf_pkg::LIN_W-1:0]           linear_speed,
    output logic signed [lwf_pkg::ANG_W-1:0]    angular_speed
);

    lwf_pkg::thresholds_t                 thr_reg;

    logic                                 s1_valid_reg;
    logic                                 s1_kind_reg;
    logic [lwf_pkg::BEAM_W-1:0]           s1_beam_reg;
    logic [lwf_pkg::DIST_W-1:0]           s1_range_reg;
    logic                                 s1_no_return_reg;

    logic                                 out_valid_reg;
    logic [lwf_pkg::LIN_W-1:0]            linear_speed_reg;
    logic signed [lwf_pkg::ANG_W-1:0]     angular_speed_reg;

    logic                                 s1_advance;
    logic                                 in_fire;
    lwf_pkg::sector_mins_t                mins;
    logic                                 cmd_valid;
    logic [lwf_pkg::LIN_W-1:0]            cmd_linear;
    logic signed [lwf_pkg::ANG_W-1:0]     cmd_angular;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.max_dist <= lwf_pkg::MAX_DIST_RST;
            thr_reg.min_dist <= lwf_pkg::MIN_DIST_RST;
            thr_reg.far_dist <= lwf_pkg::FAR_DIST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lwf_pkg::REG_MAX_DIST: thr_reg.max_dist <= cfg_data;
                lwf_pkg::REG_MIN_DIST: thr_reg.min_dist <= cfg_data;
                lwf_pkg::REG_FAR_DIST: thr_reg.far_dist <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg      <= kind;
            s1_beam_reg      <= beam_index;
            s1_range_reg     <= range_cm;
            s1_no_return_reg <= no_return;
        end
    end

    lwf_sectors u_sectors (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_en  (s1_advance && !s1_kind_reg),
        .beam_index (s1_beam_reg),
        .range_cm   (s1_range_reg),
        .no_return  (s1_no_return_reg),
        .mins       (mins)
    );

    lwf_mode_fsm u_mode_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (s1_advance && s1_kind_reg),
        .thr         (thr_reg),
        .mins        (mins),
        .cmd_valid   (cmd_valid),
        .cmd_linear  (cmd_linear),
        .cmd_angular (cmd_angular)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= s1_advance && cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && cmd_valid)
        begin
            linear_speed_reg  <= cmd_linear;
            angular_speed_reg <= cmd_angular;
        end
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = linear_speed_reg;
    assign angular_speed = angular_speed_reg;

endmodule

// ===== rtl/core/lwf_checker.sv =====
// ----------------------------------------------------------------------------
// lwf_checker
// Port-level checks for the left wall follow controller.
// ----------------------------------------------------------------------------
module lwf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                kind,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [lwf_pkg::LIN_W-1:0]           linear_speed,
    input  logic signed [lwf_pkg::ANG_W-1:0]    angular_speed
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(linear_speed)
            && $stable(angular_speed))
        else $error("result beat changed while stalled");

    // input is never held back while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a fresh command comes from a tick that passed through the input register
    a_cmd_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && kind, 2))
        else $error("command without a tick");

    // only the defined speed pairs are emitted
    a_cmd_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (linear_speed == 5'd20 && angular_speed == -8'sd30) ||
            (linear_speed == 5'd20 && angular_speed == 8'sd30) ||
            (linear_speed == 5'd30 && angular_speed == 8'sd0) ||
            (linear_speed == 5'd3 && angular_speed == 8'sd60) ||
            (linear_speed == 5'd10 && angular_speed == 8'sd0) ||
            (linear_speed == 5'd0 && angular_speed == -8'sd80))
        else $error("unexpected speed command");

endmodule

bind left_wall_follow_controller lwf_checker u_lwf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .linear_speed  (linear_speed),
    .angular_speed (angular_speed)
);
